/* rtl/dtr_pkg.sv */
// Package for the double-sided two-way ranging calculator.
// Holds the fixed field widths, fixed-point scales and saturation limits.
// No dependencies.
package dtr_pkg;

  // Default timestamp width.
  localparam int STAMP_BITS_DEF = 40;

  // Configuration register: metres per tick, unsigned Q0.32.
  localparam int          MPT_W     = 32;
  localparam logic [31:0] MPT_RESET = 32'd20151000;

  // Drift factor in signed Q.40, saturated to +-(2^39 - 1).
  localparam int          DRIFT_W    = 40;
  localparam int          DRIFT_FRAC = 40;
  localparam int          DRIFT_QB   = 40;
  localparam logic [39:0] DRIFT_MAX  = 40'h7F_FFFF_FFFF;

  // Time of flight in signed Q32.8 ticks.
  localparam int          TOF_W    = 40;
  localparam int          TOF_FRAC = 8;
  localparam int          TOF_QB   = 41;
  localparam logic [39:0] TOF_MAX  = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] TOF_MIN  = 40'h80_0000_0000;

  // Distance in signed Q16.16 metres.
  localparam int          DIST_W     = 32;
  localparam int          DIST_SHIFT = 24;
  localparam logic [31:0] DIST_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] DIST_MIN   = 32'h8000_0000;

  // Clock offset in signed ticks.
  localparam int          OFF_W     = 40;
  localparam int          OFF_SHIFT = 48;
  localparam logic [39:0] OFF_MAX   = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] OFF_MIN   = 40'h80_0000_0000;

endpackage

/* rtl/dtr_cfg_if.sv */
// Configuration write channel of the ranging calculator.
// Depends on dtr_pkg for the register width.
interface dtr_cfg_if;
  import dtr_pkg::*;

  logic             valid;
  logic             ready;
  logic [MPT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/dtr_in_if.sv */
// Input channel of the ranging calculator: the six timestamps of one exchange.
// Depends on dtr_pkg for the default timestamp width.
interface dtr_in_if #(
  parameter int STAMP_BITS = dtr_pkg::STAMP_BITS_DEF
);
  import dtr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STAMP_BITS-1:0] poll_tx_time;
  logic [STAMP_BITS-1:0] poll_rx_time;
  logic [STAMP_BITS-1:0] resp_tx_time;
  logic [STAMP_BITS-1:0] resp_rx_time;
  logic [STAMP_BITS-1:0] final_tx_time;
  logic [STAMP_BITS-1:0] final_rx_time;

  modport source (
    output valid, output poll_tx_time, output poll_rx_time, output resp_tx_time,
    output resp_rx_time, output final_tx_time, output final_rx_time, input ready
  );
  modport sink (
    input valid, input poll_tx_time, input poll_rx_time, input resp_tx_time,
    input resp_rx_time, input final_tx_time, input final_rx_time, output ready
  );
endinterface

/* rtl/dtr_out_if.sv */
// Result channel of the ranging calculator.
// Depends on dtr_pkg for the result field widths.
interface dtr_out_if;
  import dtr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     valid_res;
  logic signed [TOF_W-1:0]  flight_ticks;
  logic signed [DIST_W-1:0] distance_q16;
  logic signed [DRIFT_W-1:0] clock_drift;
  logic signed [OFF_W-1:0]  clock_offset;

  modport source (
    output valid, output valid_res, output flight_ticks, output distance_q16,
    output clock_drift, output clock_offset, input ready
  );
  modport sink (
    input valid, input valid_res, input flight_ticks, input distance_q16,
    input clock_drift, input clock_offset, output ready
  );
endinterface

/* rtl/dtr_delay.sv */
// Stall-aware delay line that carries a valid bit and a payload word.
// No dependencies.
module dtr_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         vin,
  input  logic [W-1:0] din,
  output logic         vout,
  output logic [W-1:0] dout
);

  logic [N-1:0] vs;
  logic [W-1:0] ds [0:N-1];

  // Valid bits shift with the pipeline and clear at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs[0] <= vin;
      for (int i = 1; i < N; i++) begin
        vs[i] <= vs[i-1];
      end
    end
  end

  // Payload shifts alongside the valid bits.
  always_ff @(posedge clk) begin
    if (en) begin
      ds[0] <= din;
      for (int i = 1; i < N; i++) begin
        ds[i] <= ds[i-1];
      end
    end
  end

  assign vout = vs[N-1];
  assign dout = ds[N-1];

endmodule

/* rtl/dtr_mul.sv */
// Two-stage signed multiplier built from four half-width partial products.
// No dependencies.
module dtr_mul #(
  parameter int WA = 40,
  parameter int WB = 40
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int LA = WA / 2;
  localparam int HA = WA - LA;
  localparam int LB = WB / 2;
  localparam int HB = WB - LB;
  localparam int WP = WA + WB;

  logic signed [HA-1:0] a_hi;
  logic signed [LA:0]   a_lo;
  logic signed [HB-1:0] b_hi;
  logic signed [LB:0]   b_lo;

  logic signed [HA+HB-1:0] pp_hh;
  logic signed [HA+LB:0]   pp_hl;
  logic signed [LA+HB:0]   pp_lh;
  logic signed [LA+LB+1:0] pp_ll;

  // Split operands: signed upper halves, zero-extended lower halves.
  assign a_hi = a[WA-1:LA];
  assign a_lo = {1'b0, a[LA-1:0]};
  assign b_hi = b[WB-1:LB];
  assign b_lo = {1'b0, b[LB-1:0]};

  // First stage: the four partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= a_hi * b_hi;
      pp_hl <= a_hi * b_lo;
      pp_lh <= a_lo * b_hi;
      pp_ll <= a_lo * b_lo;
    end
  end

  // Second stage: align and sum.
  always_ff @(posedge clk) begin
    if (en) begin
      p <= (WP'(pp_hh) << (LA + LB)) + (WP'(pp_hl) << LA)
         + (WP'(pp_lh) << LB) + WP'(pp_ll);
    end
  end

endmodule

/* rtl/dtr_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with overflow
// detection and a round-half-up bit. No dependencies.
module dtr_div #(
  parameter int WN = 80,
  parameter int WD = 41,
  parameter int QB = 40
) (
  input  logic          clk,
  input  logic          en,
  input  logic [WN-1:0] num,
  input  logic [WD-1:0] den,
  output logic          ovf,
  output logic [QB-1:0] quo,
  output logic          rnd
);

  localparam int HW = WN - QB;
  localparam int CW = (HW > WD) ? HW : WD;

  logic [WD-1:0] rem   [0:QB];
  logic [QB-1:0] low   [0:QB];
  logic [QB-1:0] quo_s [0:QB];
  logic [WD-1:0] dv    [0:QB];
  logic [QB:0]   ovf_s;

  // Entry stage: the upper numerator bits start the remainder; if they are
  // not below the divisor the quotient does not fit in QB bits.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= WD'(num[WN-1:QB]);
      low[0]   <= num[QB-1:0];
      quo_s[0] <= '0;
      dv[0]    <= den;
      ovf_s[0] <= CW'(num[WN-1:QB]) >= CW'(den);
    end
  end

  // One compare-and-subtract per stage.
  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [WD:0] trial;
    logic        ge;

    assign trial = {rem[k-1], low[k-1][QB-1]};
    assign ge    = trial >= {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]   <= ge ? WD'(trial - {1'b0, dv[k-1]}) : WD'(trial);
        low[k]   <= low[k-1] << 1;
        quo_s[k] <= {quo_s[k-1][QB-2:0], ge};
        dv[k]    <= dv[k-1];
        ovf_s[k] <= ovf_s[k-1];
      end
    end
  end

  assign ovf = ovf_s[QB];
  assign quo = quo_s[QB];
  // Round up when twice the remainder reaches the divisor.
  assign rnd = {rem[QB], 1'b0} >= {1'b0, dv[QB]};

endmodule

/* rtl/ds_twr_range_calculator.sv */
// Top level of the double-sided two-way ranging calculator.
// Depends on dtr_pkg, the channel interfaces, dtr_delay, dtr_mul and dtr_div.
//
// Usage:
//   stamps carries the six timestamps of one ranging exchange; result returns
//   one item per exchange: the validity flag, time of flight, distance, drift
//   and clock offset. cfg writes metres_per_tick, and is always ready; write
//   it only while no exchange is in flight.
// Latency and throughput:
//   One exchange may enter every cycle while result is not stalled. The latency
//   is set by the two bit-serial division pipelines (41 stages for the drift
//   factor, 42 for the time of flight) plus two two-stage multiplier banks and
//   the add stages.
// Stalls:
//   The whole pipeline advances together. When a result waits on result and
//   the receiver holds ready low, every stage holds and stamps.ready drops;
//   nothing is lost or repeated. Bubbles travel as cleared valid bits.
// Reset:
//   rst clears all valid bits and returns metres_per_tick to 20151000.
module ds_twr_range_calculator #(
  parameter int STAMP_BITS = dtr_pkg::STAMP_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  dtr_cfg_if.sink   cfg,
  dtr_in_if.sink    stamps,
  dtr_out_if.source result
);
  import dtr_pkg::*;

  localparam int S   = STAMP_BITS;
  localparam int SL  = S + 1;
  localparam int SN  = S + 2;
  localparam int NW  = 2 * S + 1;
  localparam int CW  = S + DRIFT_FRAC + 2;
  localparam int DW  = TOF_W + MPT_W + 1;
  localparam int SHW = DW - DIST_SHIFT;
  localparam int MW  = TOF_W + DRIFT_W;
  localparam int YW  = OFF_SHIFT + S;
  localparam int PW1 = 6 * S + 2 * SL + SN + 2;
  localparam int PW2 = 2 * SL + 2 * S + SN + DRIFT_W;
  localparam int PW3 = 3 + 2 * S + DRIFT_W;
  localparam int PW4 = 1 + 2 * S + DRIFT_W + TOF_W;

  logic en;

  // ---------------------------------------------------------------- config
  logic [MPT_W-1:0] mpt;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mpt <= MPT_RESET;
    end else if (cfg.valid) begin
      mpt <= cfg.data;
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic                v1;
  logic signed [S-1:0] r1_1, p1_1, r2_1, p2_1;
  logic [S-1:0]        t5_1, t6_1;

  // Round and reply intervals as wrap-around differences.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= stamps.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_1 <= stamps.resp_rx_time - stamps.poll_tx_time;
      p1_1 <= stamps.resp_tx_time - stamps.poll_rx_time;
      r2_1 <= stamps.final_rx_time - stamps.resp_tx_time;
      p2_1 <= stamps.final_tx_time - stamps.resp_rx_time;
      t5_1 <= stamps.final_tx_time;
      t6_1 <= stamps.final_rx_time;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic                 v2;
  logic signed [SL-1:0] l2, m2, e1_2, e2_2;
  logic signed [S-1:0]  r1_2, p1_2, r2_2, p2_2;
  logic [S-1:0]         t5_2, t6_2;

  // Local and remote totals, and the uncompensated round minus reply terms.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l2   <= SL'(p1_1) + SL'(r2_1);
      m2   <= SL'(r1_1) + SL'(p2_1);
      e1_2 <= SL'(r1_1) - SL'(p1_1);
      e2_2 <= SL'(r2_1) - SL'(p2_1);
      r1_2 <= r1_1;
      p1_2 <= p1_1;
      r2_2 <= r2_1;
      p2_2 <= p2_1;
      t5_2 <= t5_1;
      t6_2 <= t6_1;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic                 v3;
  logic signed [SN-1:0] n3c;
  logic [SN-1:0]        a3;
  logic [SL-1:0]        d3;
  logic                 neg3, lz3;
  logic signed [SN-1:0] den3;
  logic signed [SL-1:0] e1_3, e2_3;
  logic signed [S-1:0]  r1_3, p1_3, r2_3, p2_3;
  logic [S-1:0]         t5_3, t6_3;

  assign n3c = SN'(l2) - SN'(m2);

  // Magnitudes and sign for the drift division, and the flight denominator.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3   <= n3c[SN-1] ? -n3c : n3c;
      d3   <= l2[SL-1] ? -l2 : l2;
      neg3 <= n3c[SN-1] ^ l2[SL-1];
      lz3  <= (l2 == '0);
      den3 <= SN'(l2) + SN'(m2);
      e1_3 <= e1_2;
      e2_3 <= e2_2;
      r1_3 <= r1_2;
      p1_3 <= p1_2;
      r2_3 <= r2_2;
      p2_3 <= p2_2;
      t5_3 <= t5_2;
      t6_3 <= t6_2;
    end
  end

  // ---------------------------------------------------------- drift divider
  logic                ovf1, rnd1;
  logic [DRIFT_QB-1:0] q1;
  logic                vd1;
  logic [PW1-1:0]      pay1;

  logic signed [S-1:0]  r1_d1, p1_d1, r2_d1, p2_d1;
  logic signed [SL-1:0] e1_d1, e2_d1;
  logic [S-1:0]         t5_d1, t6_d1;
  logic signed [SN-1:0] den_d1;
  logic                 neg_d1, lz_d1;

  dtr_div #(
    .WN(SN + DRIFT_FRAC),
    .WD(SL),
    .QB(DRIFT_QB)
  ) u_div_drift (
    .clk(clk),
    .en (en),
    .num({a3, {DRIFT_FRAC{1'b0}}}),
    .den(d3),
    .ovf(ovf1),
    .quo(q1),
    .rnd(rnd1)
  );

  dtr_delay #(
    .W(PW1),
    .N(DRIFT_QB + 1)
  ) u_dly_drift (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .vin (v3),
    .din ({r1_3, p1_3, r2_3, p2_3, e1_3, e2_3, t5_3, t6_3, den3, neg3, lz3}),
    .vout(vd1),
    .dout(pay1)
  );

  assign {r1_d1, p1_d1, r2_d1, p2_d1, e1_d1, e2_d1, t5_d1, t6_d1, den_d1, neg_d1,
          lz_d1} = pay1;

  // ---------------------------------------------------------------- stage 4
  logic [DRIFT_QB:0]         qr1;
  logic                      sat1;
  logic [DRIFT_W-1:0]        mag1;
  logic signed [DRIFT_W-1:0] drift_c;

  logic                      v4;
  logic signed [DRIFT_W-1:0] drift4;
  logic signed [S-1:0]       r1_4, p1_4, r2_4, p2_4;
  logic signed [SL-1:0]      e1_4, e2_4;
  logic [S-1:0]              t5_4, t6_4;
  logic signed [SN-1:0]      den4;

  // Round, saturate to +-(2^39 - 1) and apply the sign; zero local total
  // gives no drift.
  always_comb begin
    qr1  = {1'b0, q1} + (DRIFT_QB + 1)'(rnd1);
    sat1 = ovf1 | qr1[DRIFT_QB] | qr1[DRIFT_W-1];
    mag1 = sat1 ? DRIFT_MAX : qr1[DRIFT_W-1:0];
    if (lz_d1) begin
      drift_c = '0;
    end else if (neg_d1) begin
      drift_c = -mag1;
    end else begin
      drift_c = mag1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drift4 <= drift_c;
      r1_4   <= r1_d1;
      p1_4   <= p1_d1;
      r2_4   <= r2_d1;
      p2_4   <= p2_d1;
      e1_4   <= e1_d1;
      e2_4   <= e2_d1;
      t5_4   <= t5_d1;
      t6_4   <= t6_d1;
      den4   <= den_d1;
    end
  end

  // ------------------------------------------------------ first multipliers
  logic signed [S+DRIFT_W-1:0] ma, mb;
  logic signed [2*S-1:0]       mc, md;
  logic                        vm1;
  logic [PW2-1:0]              pay2;

  logic signed [SL-1:0]      e1_m, e2_m;
  logic [S-1:0]              t5_m, t6_m;
  logic signed [SN-1:0]      den_m;
  logic signed [DRIFT_W-1:0] drift_m;

  dtr_mul #(.WA(S), .WB(DRIFT_W)) u_mul_rd (
    .clk(clk), .en(en), .a(r1_4), .b(drift4), .p(ma)
  );
  dtr_mul #(.WA(S), .WB(DRIFT_W)) u_mul_pd (
    .clk(clk), .en(en), .a(p2_4), .b(drift4), .p(mb)
  );
  dtr_mul #(.WA(S), .WB(S)) u_mul_rr (
    .clk(clk), .en(en), .a(r1_4), .b(r2_4), .p(mc)
  );
  dtr_mul #(.WA(S), .WB(S)) u_mul_pp (
    .clk(clk), .en(en), .a(p1_4), .b(p2_4), .p(md)
  );

  dtr_delay #(
    .W(PW2),
    .N(2)
  ) u_dly_mul1 (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .vin (v4),
    .din ({e1_4, e2_4, t5_4, t6_4, den4, drift4}),
    .vout(vm1),
    .dout(pay2)
  );

  assign {e1_m, e2_m, t5_m, t6_m, den_m, drift_m} = pay2;

  // ---------------------------------------------------------------- stage 5
  logic signed [SL+DRIFT_FRAC-1:0] e1s, e2s;
  logic signed [CW-1:0]            c1, c2;

  logic                      v5, ok5;
  logic signed [NW-1:0]      num5;
  logic signed [SN-1:0]      den5;
  logic [S-1:0]              t5_5, t6_5;
  logic signed [DRIFT_W-1:0] drift5;

  // Drift-compensated round minus reply: (round1 - reply1) * 2^40 +
  // round1 * D, and (round2 - reply2) * 2^40 - reply2 * D.
  assign e1s = {e1_m, {DRIFT_FRAC{1'b0}}};
  assign e2s = {e2_m, {DRIFT_FRAC{1'b0}}};
  assign c1  = CW'(e1s) + CW'(ma);
  assign c2  = CW'(e2s) - CW'(mb);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= vm1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok5    <= !c1[CW-1] && !c2[CW-1];
      num5   <= NW'(mc) - NW'(md);
      den5   <= den_m;
      t5_5   <= t5_m;
      t6_5   <= t6_m;
      drift5 <= drift_m;
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic                      v6, ok6, tneg6, dz6;
  logic [NW-1:0]             a6;
  logic [SN-1:0]             d6;
  logic [S-1:0]              t5_6, t6_6;
  logic signed [DRIFT_W-1:0] drift6;

  // Magnitudes and sign for the flight division.
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok6    <= ok5;
      a6     <= num5[NW-1] ? -num5 : num5;
      d6     <= den5[SN-1] ? -den5 : den5;
      tneg6  <= num5[NW-1] ^ den5[SN-1];
      dz6    <= (den5 == '0);
      t5_6   <= t5_5;
      t6_6   <= t6_5;
      drift6 <= drift5;
    end
  end

  // --------------------------------------------------------- flight divider
  logic              ovf2, rnd2;
  logic [TOF_QB-1:0] q2;
  logic              vd2;
  logic [PW3-1:0]    pay3;

  logic                      ok_d2, tneg_d2, dz_d2;
  logic [S-1:0]              t5_d2, t6_d2;
  logic signed [DRIFT_W-1:0] drift_d2;

  dtr_div #(
    .WN(NW + TOF_FRAC),
    .WD(SN),
    .QB(TOF_QB)
  ) u_div_tof (
    .clk(clk),
    .en (en),
    .num({a6, {TOF_FRAC{1'b0}}}),
    .den(d6),
    .ovf(ovf2),
    .quo(q2),
    .rnd(rnd2)
  );

  dtr_delay #(
    .W(PW3),
    .N(TOF_QB + 1)
  ) u_dly_tof (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .vin (v6),
    .din ({ok6, tneg6, dz6, t5_6, t6_6, drift6}),
    .vout(vd2),
    .dout(pay3)
  );

  assign {ok_d2, tneg_d2, dz_d2, t5_d2, t6_d2, drift_d2} = pay3;

  // ---------------------------------------------------------------- stage 7
  logic [TOF_QB:0]         qr2;
  logic                    psat2, nsat2;
  logic signed [TOF_W-1:0] tof_c;

  logic                      v7, ok7;
  logic signed [TOF_W-1:0]   tof7;
  logic [S-1:0]              t5_7, t6_7;
  logic signed [DRIFT_W-1:0] drift7;

  // Round, apply the sign and saturate to the signed 40-bit range.
  always_comb begin
    qr2   = {1'b0, q2} + (TOF_QB + 1)'(rnd2);
    psat2 = ovf2 || (qr2[TOF_QB:TOF_W-1] != '0);
    nsat2 = ovf2 || (qr2[TOF_QB:TOF_W] != '0)
         || (qr2[TOF_W-1] && (qr2[TOF_W-2:0] != '0));
    if (dz_d2) begin
      tof_c = '0;
    end else if (tneg_d2) begin
      tof_c = nsat2 ? TOF_MIN : -qr2[TOF_W-1:0];
    end else begin
      tof_c = psat2 ? TOF_MAX : qr2[TOF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= vd2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok7    <= ok_d2;
      tof7   <= tof_c;
      t5_7   <= t5_d2;
      t6_7   <= t6_d2;
      drift7 <= drift_d2;
    end
  end

  // ----------------------------------------------------- second multipliers
  logic signed [MPT_W:0]   mpt_s;
  logic signed [DW-1:0]    me;
  logic signed [MW-1:0]    mf;
  logic                    vm2;
  logic [PW4-1:0]          pay4;

  logic                      ok_m2;
  logic [S-1:0]              t5_m2, t6_m2;
  logic signed [DRIFT_W-1:0] drift_m2;
  logic signed [TOF_W-1:0]   tof_m2;

  assign mpt_s = {1'b0, mpt};

  dtr_mul #(.WA(TOF_W), .WB(MPT_W + 1)) u_mul_dist (
    .clk(clk), .en(en), .a(tof7), .b(mpt_s), .p(me)
  );
  dtr_mul #(.WA(TOF_W), .WB(DRIFT_W)) u_mul_adj (
    .clk(clk), .en(en), .a(tof7), .b(drift7), .p(mf)
  );

  dtr_delay #(
    .W(PW4),
    .N(2)
  ) u_dly_mul2 (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .vin (v7),
    .din ({ok7, t5_7, t6_7, drift7, tof7}),
    .vout(vm2),
    .dout(pay4)
  );

  assign {ok_m2, t5_m2, t6_m2, drift_m2, tof_m2} = pay4;

  // ---------------------------------------------------------------- stage 8
  logic signed [DW-1:0]           dist_half;
  logic signed [DW-1:0]           xs;
  logic signed [SHW-1:0]          sh;
  logic [SHW-DIST_W:0]            sh_top;
  logic signed [DIST_W-1:0]       dist_c;
  logic signed [TOF_W+DRIFT_FRAC-1:0] tof_sh;
  logic signed [YW-1:0]           off_half;
  logic signed [YW-1:0]           ys;

  logic                      v8, ok8;
  logic signed [TOF_W-1:0]   tof8;
  logic signed [DIST_W-1:0]  dist8;
  logic signed [DRIFT_W-1:0] drift8;
  logic [S-1:0]              adj8, t5_8, t6_8;

  // Distance: round the Q32.8 x Q0.32 product to Q16.16 and saturate.
  assign dist_half = DW'(1) << (DIST_SHIFT - 1);
  assign xs        = me + dist_half;
  assign sh        = xs[DW-1:DIST_SHIFT];
  assign sh_top    = sh[SHW-1:DIST_W-1];

  always_comb begin
    if ((&sh_top) || !(|sh_top)) begin
      dist_c = sh[DIST_W-1:0];
    end else begin
      dist_c = sh[SHW-1] ? DIST_MIN : DIST_MAX;
    end
  end

  // Offset correction: round(tof * (1 + D)) in ticks, kept modulo 2^S.
  assign tof_sh   = {tof_m2, {DRIFT_FRAC{1'b0}}};
  assign off_half = YW'(1) << (OFF_SHIFT - 1);
  assign ys       = YW'(tof_sh) + YW'(mf) + off_half;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= vm2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok8    <= ok_m2;
      tof8   <= tof_m2;
      dist8  <= dist_c;
      drift8 <= drift_m2;
      adj8   <= ys[YW-1:OFF_SHIFT];
      t5_8   <= t5_m2;
      t6_8   <= t6_m2;
    end
  end

  // ---------------------------------------------------------- output stage
  logic signed [S-1:0]     off_c;
  logic signed [OFF_W-1:0] off_s;

  logic                      v9, ok9;
  logic signed [TOF_W-1:0]   tof9;
  logic signed [DIST_W-1:0]  dist9;
  logic signed [DRIFT_W-1:0] drift9;
  logic signed [OFF_W-1:0]   off9;

  assign off_c = t5_8 + adj8 - t6_8;

  // Saturate the offset to 40 bits when timestamps are wider.
  if (S > OFF_W) begin : g_off_sat
    logic [S-OFF_W:0] off_top;

    assign off_top = off_c[S-1:OFF_W-1];

    always_comb begin
      if ((&off_top) || !(|off_top)) begin
        off_s = off_c[OFF_W-1:0];
      end else begin
        off_s = off_c[S-1] ? OFF_MIN : OFF_MAX;
      end
    end
  end else begin : g_off_ext
    assign off_s = OFF_W'(off_c);
  end

  // The pipeline advances whenever the output register is free or drains.
  assign en           = !v9 || result.ready;
  assign stamps.ready = en;

  // A rejected exchange reports zeros in every field.
  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok9    <= ok8;
      tof9   <= ok8 ? tof8 : '0;
      dist9  <= ok8 ? dist8 : '0;
      drift9 <= ok8 ? -drift8 : '0;
      off9   <= ok8 ? off_s : '0;
    end
  end

  assign result.valid        = v9;
  assign result.valid_res    = ok9;
  assign result.flight_ticks = tof9;
  assign result.distance_q16 = dist9;
  assign result.clock_drift  = drift9;
  assign result.clock_offset = off9;

  // ------------------------------------------------------------ assertions
  // No result is offered in the cycle after reset.
  a_reset_empty : assert property (@(posedge clk) $past(rst) |-> !result.valid)
    else $error("result offered right after reset");

  // A rejected exchange carries only zero fields.
  a_reject_zero : assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.valid_res |->
      result.flight_ticks == '0 && result.distance_q16 == '0 &&
      result.clock_drift == '0 && result.clock_offset == '0)
    else $error("rejected exchange has nonzero fields");

  // The drift saturates symmetrically, so the most negative code never appears.
  a_drift_range : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.clock_drift != {1'b1, {(DRIFT_W - 1){1'b0}}})
    else $error("drift outside its saturated range");

  // A transfer on stamps always enters the first stage.
  a_enter : assert property (@(posedge clk) disable iff (rst)
    stamps.valid && stamps.ready |=> v1)
    else $error("accepted exchange lost at pipeline entry");

  // While the receiver stalls, the waiting result holds.
  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    !en |=> v9 && $stable(tof9) && $stable(off9))
    else $error("result changed during a stall");

endmodule
